@@ sv/r30bg_pkg.sv @@
// ----------------------------------------------------------------------------
// r30bg_pkg
// Shared types, constants and the Rule 30 row update for the block generator.
// ----------------------------------------------------------------------------
package r30bg_pkg;

  localparam int ROW_CELLS   = 128;
  localparam int CENTRE_CELL = ROW_CELLS / 2;
  localparam int ROW_IDX_W   = $clog2(ROW_CELLS);
  localparam int HALF_W      = ROW_CELLS / 2;
  localparam int GENERATIONS_DEF = 128;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_GEN  = 1'b1;

  typedef struct packed {
    logic              command;
    logic [HALF_W-1:0] seed_high;
    logic [HALF_W-1:0] seed_low;
  } in_word_t;

  typedef struct packed {
    logic [HALF_W-1:0] block_high;
    logic [HALF_W-1:0] block_low;
  } out_word_t;

  typedef struct packed {
    logic                 load;
    logic                 start;
    logic                 step;
    logic                 emit;
    logic [ROW_IDX_W-1:0] gen_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_sts_t;

  // cell c lives at bit c-1; row wraps around
  function automatic logic [ROW_CELLS-1:0] r30bg_advance(input logic [ROW_CELLS-1:0] row);
    logic [ROW_CELLS-1:0] up;
    logic [ROW_CELLS-1:0] dn;
    up = {row[0], row[ROW_CELLS-1:1]};
    dn = {row[ROW_CELLS-2:0], row[ROW_CELLS-1]};
    return up ^ (row | dn);
  endfunction

endpackage

@@ sv/r30bg_ctrl.sv @@
// ----------------------------------------------------------------------------
// r30bg_ctrl
// Sequencer: accepts commands, counts generations, hands the block to output.
// ----------------------------------------------------------------------------
module r30bg_ctrl #(
  parameter int GENERATIONS = r30bg_pkg::GENERATIONS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_command,
  output logic                in_stall,
  output r30bg_pkg::dp_cmd_t  cmd,
  input  r30bg_pkg::dp_sts_t  sts
);
  import r30bg_pkg::*;

  localparam int CNT_W = (GENERATIONS > 1) ? $clog2(GENERATIONS) : 1;
  localparam logic [CNT_W-1:0] LAST_GEN = CNT_W'(GENERATIONS - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             accept;

  always_comb begin
    accept      = in_valid && (state_r == ST_IDLE);
    in_stall    = (state_r != ST_IDLE);
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    cmd.load    = accept && (in_command == CMD_LOAD);
    cmd.start   = accept && (in_command == CMD_GEN);
    cmd.step    = 1'b0;
    cmd.emit    = 1'b0;
    cmd.gen_idx = ROW_IDX_W'(cnt_r);
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.start) begin
          state_nxt = ST_RUN;
          cnt_nxt   = '0;
        end
      end
      ST_RUN: begin
        cmd.step = 1'b1;
        if (cnt_r == LAST_GEN) begin
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DONE: begin
        // wait for the output register to free up
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

@@ sv/r30bg_dp.sv @@
// ----------------------------------------------------------------------------
// r30bg_dp
// Datapath: 128-cell row, block collector and output register.
// ----------------------------------------------------------------------------
module r30bg_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  r30bg_pkg::in_word_t  in_word,
  input  r30bg_pkg::dp_cmd_t   cmd,
  output r30bg_pkg::dp_sts_t   sts,
  output logic                 out_valid,
  input  logic                 out_stall,
  output r30bg_pkg::out_word_t out_word
);
  import r30bg_pkg::*;

  logic [ROW_CELLS-1:0] row_r, row_nxt;
  logic [ROW_CELLS-1:0] blk_r, blk_nxt;
  logic [ROW_CELLS-1:0] row_adv;
  logic                 out_valid_r, out_valid_nxt;
  out_word_t            out_word_r, out_word_nxt;

  always_comb begin
    row_adv       = r30bg_advance(row_r);
    row_nxt       = row_r;
    blk_nxt       = blk_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    sts.out_free  = !out_valid_r || !out_stall;

    if (cmd.load) begin
      row_nxt = {in_word.seed_high, in_word.seed_low};
    end else if (cmd.start) begin
      blk_nxt = '0;
      // empty row gets a single live centre cell
      if (row_r == '0) begin
        row_nxt = ROW_CELLS'(1) << (CENTRE_CELL - 1);
      end
    end else if (cmd.step) begin
      row_nxt              = row_adv;
      blk_nxt[cmd.gen_idx] = row_adv[CENTRE_CELL-1];
    end

    if (cmd.emit) begin
      out_valid_nxt           = 1'b1;
      out_word_nxt.block_high = blk_r[ROW_CELLS-1:HALF_W];
      out_word_nxt.block_low  = blk_r[HALF_W-1:0];
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blk_r      <= blk_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

@@ sv/rule30_block_generator.sv @@
// ----------------------------------------------------------------------------
// rule30_block_generator
// Rule 30 generator on a circular 128-cell row, one block per generate word.
// Load word: row replaced, no result; next word can be taken the next cycle.
// Generate word: one generation per cycle; out_valid rises once GENERATIONS
// generations are done and the output register is free to take the block.
// Next word is taken only after the block moves to the output register, later
// while the previous block still sits stalled in the output register.
// Reset clears the row, drops out_valid and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module rule30_block_generator #(
  parameter int GENERATIONS = r30bg_pkg::GENERATIONS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  r30bg_pkg::in_word_t  in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output r30bg_pkg::out_word_t out_word
);
  import r30bg_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  r30bg_ctrl #(
    .GENERATIONS (GENERATIONS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_word.command),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .sts        (sts)
  );

  r30bg_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

@@ sv/r30bg_chk.sv @@
// ----------------------------------------------------------------------------
// r30bg_chk
// Port-level checks on the block generator, bound to the top level.
// ----------------------------------------------------------------------------
module r30bg_chk (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input r30bg_pkg::in_word_t  in_word,
  input logic                 out_valid,
  input logic                 out_stall,
  input r30bg_pkg::out_word_t out_word
);
  import r30bg_pkg::*;

  // held result word must not move
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  // a generate word keeps the input stalled while it runs
  a_gen_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_word.command == CMD_GEN) |=> in_stall)
    else $error("input taken during generation");

  // after a load word the input is free again in the next cycle
  a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_word.command == CMD_LOAD) |=> !in_stall)
    else $error("load word held input off");

  // a load never produces a result
  a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_word.command == CMD_LOAD) && !out_valid |=> !out_valid)
    else $error("result appeared after load");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("not idle after reset");

endmodule

bind rule30_block_generator r30bg_chk u_r30bg_chk (.*);
